@@ rtl/core/rcsfd_pkg.sv @@
// Shared types and constants for the servo frame decoder.
// No dependencies.
package rcsfd_pkg;

  localparam int unsigned FrameBytes  = 32;
  localparam int unsigned MaxChannels = 14;
  localparam int unsigned PosW        = $clog2(FrameBytes);
  localparam int unsigned ChanW       = 4;

  localparam logic [7:0]  HdrFirst  = 8'h20;
  localparam logic [7:0]  HdrSecond = 8'h40;
  localparam logic [15:0] SumBase   = 16'hFFFF;

  localparam logic [PosW-1:0] PosHdr0   = PosW'(0);
  localparam logic [PosW-1:0] PosHdr1   = PosW'(1);
  localparam logic [PosW-1:0] PosSumLo  = PosW'(FrameBytes - 2);
  localparam logic [PosW-1:0] PosSumHi  = PosW'(FrameBytes - 1);
  localparam logic [PosW-1:0] PosChan0  = PosW'(2);

  typedef enum logic [1:0] {
    STATE_IDLE = 2'b01,
    STATE_EMIT = 2'b10
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic take_byte;
    logic emit_load;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic frame_match;
    logic out_busy;
    logic last_chan;
  } status_t;

endpackage

@@ rtl/core/rc_serial_frame_decoder.sv @@
// Servo frame decoder top level: 32-byte frames, header 0x20 0x40, 16-bit checksum.
// One byte is taken per cycle; a good frame's last byte starts a burst of CHANNEL_COUNT
// transactions, one per cycle while out_ready_i is high, during which no byte is taken.
// First channel is loaded in the emit state entered after the final byte. Reset (rst_ni,
// async, low) restarts the header hunt and empties the output register; no clearing pass.
// Depends on rcsfd_pkg, rcsfd_ctrl, rcsfd_datapath.
module rc_serial_frame_decoder import rcsfd_pkg::*; #(
  parameter int unsigned CHANNEL_COUNT = 14
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [7:0]       rx_byte_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [ChanW-1:0] channel_index_o,
  output logic [15:0]      channel_value_o,
  output logic             last_channel_o
);

  cmd_t    cmd;
  status_t status;

  rcsfd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rcsfd_datapath #(
    .CHANNEL_COUNT (CHANNEL_COUNT)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .rx_byte_i       (rx_byte_i),
    .out_ready_i     (out_ready_i),
    .out_valid_o     (out_valid_o),
    .channel_index_o (channel_index_o),
    .channel_value_o (channel_value_o),
    .last_channel_o  (last_channel_o)
  );

endmodule

@@ rtl/core/rcsfd_datapath.sv @@
// Datapath: byte position, running checksum, channel word store, output register.
// Depends on rcsfd_pkg.
module rcsfd_datapath import rcsfd_pkg::*; #(
  parameter int unsigned CHANNEL_COUNT = 14
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  output status_t           status_o,
  input  logic [7:0]        rx_byte_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic [ChanW-1:0]  channel_index_o,
  output logic [15:0]       channel_value_o,
  output logic              last_channel_o
);

  localparam logic [ChanW-1:0] LastIdx = ChanW'(CHANNEL_COUNT - 1);

  logic [PosW-1:0]  pos_q, pos_d;
  logic [15:0]      acc_q, acc_d;
  logic [7:0]       sum_lo_q;
  logic [ChanW-1:0] chan_q, chan_d;
  logic             out_valid_q, out_valid_d;
  logic [ChanW-1:0] idx_q;
  logic [15:0]      val_q;
  logic             last_q;
  logic [15:0]      words_q [MaxChannels];

  logic             hdr_bad;
  logic             in_chan_span;
  logic [ChanW-1:0] word_sel;

  assign hdr_bad = ((pos_q == PosHdr0) && (rx_byte_i != HdrFirst)) ||
                   ((pos_q == PosHdr1) && (rx_byte_i != HdrSecond));
  assign in_chan_span = (pos_q >= PosChan0) && (pos_q < PosSumLo);
  assign word_sel = pos_q[PosW-1:1] - ChanW'(1);

  assign status_o.frame_match = (pos_q == PosSumHi) && ({rx_byte_i, sum_lo_q} == acc_q);
  assign status_o.out_busy    = out_valid_q && !out_ready_i;
  assign status_o.last_chan   = (chan_q == LastIdx);

  always_comb begin
    pos_d = pos_q;
    acc_d = acc_q;
    if (cmd_i.take_byte) begin
      if (hdr_bad) begin
        pos_d = PosHdr0;
      end else begin
        pos_d = (pos_q == PosSumHi) ? PosHdr0 : pos_q + PosW'(1);
        if (pos_q == PosHdr0) begin
          acc_d = SumBase - {8'h00, rx_byte_i};
        end else if (pos_q < PosSumLo) begin
          acc_d = acc_q - {8'h00, rx_byte_i};
        end
      end
    end
  end

  always_comb begin
    chan_d      = chan_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.emit_load) begin
      out_valid_d = 1'b1;
      chan_d      = status_o.last_chan ? '0 : chan_q + ChanW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      chan_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      chan_q      <= chan_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (cmd_i.take_byte && (pos_q == PosSumLo)) begin
      sum_lo_q <= rx_byte_i;
    end
    // channel bytes pair up into little-endian words
    if (cmd_i.take_byte && in_chan_span) begin
      if (pos_q[0]) begin
        words_q[word_sel][15:8] <= rx_byte_i;
      end else begin
        words_q[word_sel][7:0] <= rx_byte_i;
      end
    end
    if (cmd_i.emit_load) begin
      idx_q  <= chan_q;
      val_q  <= words_q[chan_q];
      last_q <= status_o.last_chan;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign channel_index_o = idx_q;
  assign channel_value_o = val_q;
  assign last_channel_o  = last_q;

endmodule

@@ rtl/core/rcsfd_ctrl.sv @@
// Controller: byte intake versus channel burst sequencing.
// Depends on rcsfd_pkg.
module rcsfd_ctrl import rcsfd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;

  assign in_ready_o      = (state_q == STATE_IDLE);
  assign cmd_o.take_byte = in_valid_i && in_ready_o;
  assign cmd_o.emit_load = (state_q == STATE_EMIT) && !status_i.out_busy;

  always_comb begin
    state_d = state_q;
    case (state_q)
      STATE_IDLE: begin
        if (cmd_o.take_byte && status_i.frame_match) begin
          state_d = STATE_EMIT;
        end
      end
      STATE_EMIT: begin
        if (cmd_o.emit_load && status_i.last_chan) begin
          state_d = STATE_IDLE;
        end
      end
      default: state_d = STATE_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= STATE_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
